// ----- hdl/xhbk_pkg.sv -----
package xhbk_pkg;

    // key length field and word position widths
    localparam int LENGTH_BITS = 16;
    localparam int LEN_W       = 16;
    localparam int POS_W       = LENGTH_BITS - 2;
    localparam int TBITS_W     = 6;
    localparam int WORD_W      = 32;

    // hash primes and reset seed
    localparam logic [WORD_W-1:0] PRIME1     = 32'd2654435761;
    localparam logic [WORD_W-1:0] PRIME2     = 32'd2246822519;
    localparam logic [WORD_W-1:0] PRIME3     = 32'd3266489917;
    localparam logic [WORD_W-1:0] PRIME4     = 32'd668265263;
    localparam logic [WORD_W-1:0] PRIME5     = 32'd374761393;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'h9747b28c;

    // configuration register indexes
    localparam logic REG_HASH_SEED  = 1'b0;
    localparam logic REG_TABLE_BITS = 1'b1;

    // kind of mixing round
    typedef enum logic [1:0] {
        RND_LANE,
        RND_WORD,
        RND_BYTE
    } round_t;

    // operation of the shared multiplier
    typedef enum logic [2:0] {
        MIX_NONE,
        MIX_PRE,
        MIX_ROT,
        MIX_AV1,
        MIX_AV2
    } mix_op_t;

    typedef struct packed {
        mix_op_t op;
        round_t  rtype;
    } mix_cmd_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BODY,
        ST_AFTER_LANE,
        ST_BYTES,
        ST_TWELVE,
        ST_END,
        ST_FIX,
        ST_R_PRE,
        ST_R_ROT,
        ST_R_WB,
        ST_AV1,
        ST_AV2,
        ST_AV3
    } state_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] r);
        logic [5:0] back;
        back = 6'd32 - {1'b0, r};
        return (x << r) | (x >> back);
    endfunction

endpackage

// ----- hdl/xhbk_mix_unit.sv -----
module xhbk_mix_unit import xhbk_pkg::*;
(
    input  logic              clk,
    input  mix_cmd_t          cmd,
    input  logic [WORD_W-1:0] opnd,
    input  logic [WORD_W-1:0] acc,
    output logic [WORD_W-1:0] prod
);

    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic [WORD_W-1:0] k_pre;
    logic [WORD_W-1:0] k_post;
    logic [4:0]        rot;
    logic              en;

    // round constants by kind
    always_comb
    begin
        case (cmd.rtype)
            RND_LANE:
            begin
                k_pre  = PRIME2;
                k_post = PRIME1;
                rot    = 5'd13;
            end
            RND_WORD:
            begin
                k_pre  = PRIME3;
                k_post = PRIME4;
                rot    = 5'd17;
            end
            RND_BYTE:
            begin
                k_pre  = PRIME5;
                k_post = PRIME1;
                rot    = 5'd11;
            end
            default:
            begin
                k_pre  = PRIME3;
                k_post = PRIME4;
                rot    = 5'd17;
            end
        endcase
    end

    // operand selection for the one multiplier
    always_comb
    begin
        en    = 1'b1;
        mul_a = opnd;
        mul_b = k_pre;
        case (cmd.op)
            MIX_PRE:
            begin
                mul_a = opnd;
                mul_b = k_pre;
            end
            MIX_ROT:
            begin
                mul_a = rotl32(acc + prod_reg, rot);
                mul_b = k_post;
            end
            MIX_AV1:
            begin
                mul_a = acc ^ (acc >> 15);
                mul_b = PRIME2;
            end
            MIX_AV2:
            begin
                mul_a = prod_reg ^ (prod_reg >> 13);
                mul_b = PRIME3;
            end
            default:
            begin
                en = 1'b0;
            end
        endcase
    end

    // registered low half of the product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/xxhash_style_byte_key_hash_top.sv -----
// Hashes a byte key that arrives as little-endian 32-bit words (first byte in
// bits 7:0), each word carrying the total key length, with an xxHash32-style
// scheme; on the word marked tlast one word comes out holding the 32-bit hash
// and the hash masked to the low table_bits bits (all 32 bits when table_bits
// is 32, zero when it is 0 or above 32). A key of zero length gives zero for
// both. All rounds run on one shared 32x32 multiplier with a registered
// product, two multiplies per round, under a small sequencer that takes one
// word at a time; each round runs its pre-multiply, rotate and write-back
// states, a tail of up to three bytes gets one round per byte, and the
// final word adds fixup, a rehash of the buffered words of a 12-byte key
// where needed, and avalanche, its result written once the output register
// is free. A finished result waits in an output register, so the next key
// is taken while it is still pending. Configuration writes (index 0 seed,
// index 1 table_bits) are taken at any clock edge and belong between keys.
module xxhash_style_byte_key_hash_top import xhbk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // key_word[31:0], key_length[47:32]
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,   // hash_value[31:0], table_index[63:32]
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [WORD_W-1:0]   cfg_data
);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [WORD_W-1:0]    seed_reg;
    logic [TBITS_W-1:0]   tbits_reg;
    logic [WORD_W-1:0]    lane_reg [4];
    logic [WORD_W-1:0]    lane_next [4];
    logic [WORD_W-1:0]    rh_reg, rh_next;
    logic [WORD_W-1:0]    saved_reg [3];
    logic                 saved_we;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_W-1:0]    w_reg, w_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 last_reg, last_next;
    logic [POS_W-1:0]     p_reg, p_next;
    round_t               rtype_reg, rtype_next;
    logic                 tgt_rh_reg, tgt_rh_next;
    logic [1:0]           tgt_idx_reg, tgt_idx_next;
    logic [WORD_W-1:0]    opnd_reg, opnd_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [1:0]           lim_reg, lim_next;
    logic                 fin_reg, fin_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]    hash_out_reg, hash_out_next;
    logic [WORD_W-1:0]    idx_out_reg, idx_out_next;

    logic [WORD_W-1:0]    in_word;
    logic [LEN_W-1:0]     in_len;
    logic                 accept;
    mix_cmd_t             cmd;
    logic [WORD_W-1:0]    mix_acc;
    logic [WORD_W-1:0]    prod;
    logic [WORD_W-1:0]    comb3, comb4, len32;
    logic [LEN_W-1:0]     bw, p16, start16, rem;
    logic                 len_z, len_ge16, len_12;
    logic                 in_lane16, p_end16, early16;
    logic                 slot_free;
    logic [WORD_W-1:0]    hash_fin, mask;
    logic [WORD_W-1:0]    byte_sel, saved_sel;

    assign in_word  = s_tdata[31:0];
    assign in_len   = s_tdata[47:32];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {idx_out_reg, hash_out_reg};

    // shared multiplier
    assign mix_acc = (state_reg == ST_R_ROT && !tgt_rh_reg) ? lane_reg[tgt_idx_reg] : rh_reg;

    xhbk_mix_unit u_mix
    (
        .clk  (clk),
        .cmd  (cmd),
        .opnd (opnd_reg),
        .acc  (mix_acc),
        .prod (prod)
    );

    // key shape decode from the held word
    assign len32     = WORD_W'(len_reg);
    assign len_z     = (len_reg == '0);
    assign len_ge16  = (len_reg >= LEN_W'(16));
    assign len_12    = (len_reg == LEN_W'(12));
    assign bw        = {len_reg[LEN_W-1:4], 2'b00};
    assign p16       = LEN_W'(p_reg);
    assign start16   = LEN_W'({p_reg, 2'b00});
    assign rem       = len_reg - start16;
    assign in_lane16 = len_ge16 && (p16 < bw);
    assign p_end16   = (p16 == bw - LEN_W'(1));
    assign early16   = ((p16 + LEN_W'(1)) < bw);

    // lane combine
    assign comb3 = rotl32(lane_reg[0], 5'd1) + rotl32(lane_reg[1], 5'd7)
                 + rotl32(lane_reg[2], 5'd12);
    assign comb4 = comb3 + rotl32(lane_reg[3], 5'd18);

    // final xor shift and table mask
    assign hash_fin = prod ^ (prod >> 16);
    always_comb
    begin
        if (tbits_reg == '0 || tbits_reg > TBITS_W'(32))
        begin
            mask = '0;
        end
        else
        begin
            mask = {WORD_W{1'b1}} >> (TBITS_W'(32) - tbits_reg);
        end
    end

    assign slot_free = !out_valid_reg || m_tready;

    // tail operand picks
    always_comb
    begin
        case (cnt_reg)
            2'd0:    byte_sel = {24'd0, w_reg[7:0]};
            2'd1:    byte_sel = {24'd0, w_reg[15:8]};
            2'd2:    byte_sel = {24'd0, w_reg[23:16]};
            default: byte_sel = {24'd0, w_reg[31:24]};
        endcase
        case (cnt_reg)
            2'd0:    saved_sel = saved_reg[0];
            2'd1:    saved_sel = saved_reg[1];
            default: saved_sel = saved_reg[2];
        endcase
    end

    // sequencer next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        lane_next      = lane_reg;
        rh_next        = rh_reg;
        pos_next       = pos_reg;
        w_next         = w_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        p_next         = p_reg;
        rtype_next     = rtype_reg;
        tgt_rh_next    = tgt_rh_reg;
        tgt_idx_next   = tgt_idx_reg;
        opnd_next      = opnd_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        fin_next       = fin_reg;
        saved_we       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        hash_out_next  = hash_out_reg;
        idx_out_next   = idx_out_reg;
        cmd.op         = MIX_NONE;
        cmd.rtype      = rtype_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    w_next    = in_word;
                    len_next  = in_len;
                    last_next = s_tlast;
                    p_next    = pos_reg;
                    fin_next  = 1'b0;
                    if (in_len != '0 && pos_reg == '0)
                    begin
                        lane_next[0] = seed_reg + PRIME1 + PRIME2;
                        lane_next[1] = seed_reg + PRIME2;
                        lane_next[2] = seed_reg;
                        lane_next[3] = seed_reg - PRIME1;
                        rh_next      = seed_reg + PRIME5 + WORD_W'(in_len);
                    end
                    if (s_tlast)
                    begin
                        pos_next = '0;
                    end
                    else if (pos_reg < POS_MAX)
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    state_next = ST_BODY;
                end
            end

            ST_BODY:
            begin
                if (len_z)
                begin
                    state_next = ST_END;
                end
                else if (in_lane16 || (len_12 && p_reg < POS_W'(3)))
                begin
                    saved_we     = len_12;
                    rtype_next   = RND_LANE;
                    tgt_rh_next  = 1'b0;
                    tgt_idx_next = p_reg[1:0];
                    opnd_next    = w_reg;
                    ret_next     = ST_AFTER_LANE;
                    state_next   = ST_R_PRE;
                end
                else if (len_12 || start16 >= len_reg)
                begin
                    state_next = ST_END;
                end
                else if (rem >= LEN_W'(4))
                begin
                    rtype_next  = RND_WORD;
                    tgt_rh_next = 1'b1;
                    opnd_next   = w_reg;
                    ret_next    = ST_END;
                    state_next  = ST_R_PRE;
                end
                else
                begin
                    cnt_next   = 2'd0;
                    lim_next   = rem[1:0];
                    state_next = ST_BYTES;
                end
            end

            ST_AFTER_LANE:
            begin
                if (len_ge16 && p_end16)
                begin
                    rh_next    = comb4 + len32;
                    state_next = ST_END;
                end
                else if (len_12 && p_reg == POS_W'(2))
                begin
                    rh_next    = comb3 + len32;
                    cnt_next   = 2'd0;
                    lim_next   = 2'd3;
                    state_next = ST_TWELVE;
                end
                else
                begin
                    state_next = ST_END;
                end
            end

            // rehash the buffered words of a 12-byte key
            ST_TWELVE:
            begin
                if (cnt_reg < lim_reg)
                begin
                    rtype_next  = RND_WORD;
                    tgt_rh_next = 1'b1;
                    opnd_next   = saved_sel;
                    ret_next    = ST_TWELVE;
                    state_next  = ST_R_PRE;
                end
                else
                begin
                    state_next = fin_reg ? ST_AV1 : ST_END;
                end
            end

            // trailing bytes of a partial word
            ST_BYTES:
            begin
                if (cnt_reg < lim_reg)
                begin
                    rtype_next  = RND_BYTE;
                    tgt_rh_next = 1'b1;
                    opnd_next   = byte_sel;
                    ret_next    = ST_BYTES;
                    state_next  = ST_R_PRE;
                end
                else
                begin
                    state_next = ST_END;
                end
            end

            ST_END:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_z)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        hash_out_next  = '0;
                        idx_out_next   = '0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_FIX;
                end
            end

            // fixup on the last word, closing lanes left incomplete when the key ended early
            ST_FIX:
            begin
                fin_next = 1'b1;
                if (len_ge16 && early16)
                begin
                    rh_next    = comb4 + len32;
                    state_next = ST_AV1;
                end
                else if (len_12 && p_reg < POS_W'(2))
                begin
                    rh_next    = comb3 + len32;
                    cnt_next   = 2'd0;
                    lim_next   = p_reg[1:0] + 2'd1;
                    state_next = ST_TWELVE;
                end
                else
                begin
                    state_next = ST_AV1;
                end
            end

            ST_R_PRE:
            begin
                cmd.op     = MIX_PRE;
                state_next = ST_R_ROT;
            end

            ST_R_ROT:
            begin
                cmd.op     = MIX_ROT;
                state_next = ST_R_WB;
            end

            ST_R_WB:
            begin
                if (tgt_rh_reg)
                begin
                    rh_next = prod;
                end
                else
                begin
                    lane_next[tgt_idx_reg] = prod;
                end
                cnt_next   = cnt_reg + 2'd1;
                state_next = ret_reg;
            end

            ST_AV1:
            begin
                cmd.op     = MIX_AV1;
                state_next = ST_AV2;
            end

            ST_AV2:
            begin
                cmd.op     = MIX_AV2;
                state_next = ST_AV3;
            end

            ST_AV3:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    hash_out_next  = hash_fin;
                    idx_out_next   = hash_fin & mask;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            seed_reg      <= SEED_RESET;
            tbits_reg     <= TBITS_W'(32);
            lane_reg[0]   <= '0;
            lane_reg[1]   <= '0;
            lane_reg[2]   <= '0;
            lane_reg[3]   <= '0;
            rh_reg        <= '0;
            pos_reg       <= '0;
            last_reg      <= 1'b0;
            len_reg       <= '0;
            p_reg         <= '0;
            cnt_reg       <= '0;
            lim_reg       <= '0;
            fin_reg       <= 1'b0;
            rtype_reg     <= RND_WORD;
            tgt_rh_reg    <= 1'b1;
            tgt_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            lane_reg      <= lane_next;
            rh_reg        <= rh_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            len_reg       <= len_next;
            p_reg         <= p_next;
            cnt_reg       <= cnt_next;
            lim_reg       <= lim_next;
            fin_reg       <= fin_next;
            rtype_reg     <= rtype_next;
            tgt_rh_reg    <= tgt_rh_next;
            tgt_idx_reg   <= tgt_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == REG_HASH_SEED)
            begin
                seed_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_TABLE_BITS)
            begin
                tbits_reg <= cfg_data[TBITS_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        opnd_reg     <= opnd_next;
        hash_out_reg <= hash_out_next;
        idx_out_reg  <= idx_out_next;
        if (saved_we)
        begin
            saved_reg[p_reg[1:0]] <= w_reg;
        end
    end

endmodule

// ----- test/tb_xxhash_style_byte_key_hash_top.sv -----
`timescale 1ns / 1ps

module tb_xxhash_style_byte_key_hash_top;
    import xhbk_pkg::*;

    localparam int POS_LIMIT  = (1 << POS_W) - 1;
    localparam int HOLD_LONG  = 400;
    localparam int DRAIN_WAIT = 40;
    localparam int PHASE_WORDS = 150;

    // one expected output word
    typedef struct packed {
        logic [WORD_W-1:0] hash;
        logic [WORD_W-1:0] index;
    } hash_result_t;

    // key hash predictor plus the queue of hashes still owed by the block
    class key_hash_tracker;
        logic [WORD_W-1:0] seed;
        logic [TBITS_W-1:0] tbits;
        logic [WORD_W-1:0] lanes [4];
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] saved [3];
        int pos;
        hash_result_t owed_hashes [$];
        int errors;

        function new();
            seed   = SEED_RESET;
            tbits  = 6'd32;
            acc    = '0;
            pos    = 0;
            errors = 0;
            foreach (lanes[i]) lanes[i] = '0;
            foreach (saved[i]) saved[i] = '0;
        endfunction

        function void set_reg(logic idx, logic [WORD_W-1:0] d);
            if (idx == REG_HASH_SEED)
                seed = d;
            else
                tbits = d[TBITS_W-1:0];
        endfunction

        function int pending();
            return owed_hashes.size();
        endfunction

        function logic [WORD_W-1:0] rol(logic [WORD_W-1:0] x, int r);
            return (x << r) | (x >> (32 - r));
        endfunction

        function logic [WORD_W-1:0] lane_mix(logic [WORD_W-1:0] v, logic [WORD_W-1:0] w);
            v = v + w * PRIME2;
            v = rol(v, 13);
            return v * PRIME1;
        endfunction

        function logic [WORD_W-1:0] word_mix(logic [WORD_W-1:0] h, logic [WORD_W-1:0] w);
            h = h + w * PRIME3;
            h = rol(h, 17);
            return h * PRIME4;
        endfunction

        function logic [WORD_W-1:0] byte_mix(logic [WORD_W-1:0] h, logic [WORD_W-1:0] b);
            h = h + b * PRIME5;
            h = rol(h, 11);
            return h * PRIME1;
        endfunction

        function logic [WORD_W-1:0] merge_lanes(int count);
            logic [WORD_W-1:0] h;
            h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12);
            if (count == 4)
                h = h + rol(lanes[3], 18);
            return h;
        endfunction

        // 12-byte key: merge three lanes, then rehash the buffered words
        function void close_twelve(int words, logic [WORD_W-1:0] len32);
            acc = merge_lanes(3) + len32;
            for (int i = 0; i < words && i < 3; i++)
                acc = word_mix(acc, saved[i]);
        endfunction

        // word after the blocks: whole word round, per-byte rounds when partial, none past the length
        function void mix_tail(int p, int l, logic [WORD_W-1:0] w);
            int start;
            int rem;
            start = p * 4;
            if (start >= l)
                return;
            rem = l - start;
            if (rem >= 4)
            begin
                acc = word_mix(acc, w);
                return;
            end
            for (int i = 0; i < rem; i++)
                acc = byte_mix(acc, (w >> (8 * i)) & 32'hff);
        endfunction

        function void note_word(logic [WORD_W-1:0] w, logic [LEN_W-1:0] len, bit last);
            int p;
            int l;
            int bw;
            logic [WORD_W-1:0] len32;
            logic [WORD_W-1:0] h;
            logic [63:0] mask;
            hash_result_t res;
            p     = pos;
            l     = len;
            len32 = {16'd0, len};
            bw    = (l >> 4) * 4;

            if (l != 0)
            begin
                if (p == 0)
                begin
                    lanes[0] = seed + PRIME1 + PRIME2;
                    lanes[1] = seed + PRIME2;
                    lanes[2] = seed;
                    lanes[3] = seed - PRIME1;
                    acc      = seed + PRIME5 + len32;
                end
                if (l >= 16)
                begin
                    if (p < bw)
                    begin
                        lanes[p % 4] = lane_mix(lanes[p % 4], w);
                        if (p == bw - 1)
                            acc = merge_lanes(4) + len32;
                    end
                    else
                        mix_tail(p, l, w);
                end
                else if (l == 12)
                begin
                    if (p < 3)
                    begin
                        lanes[p] = lane_mix(lanes[p], w);
                        saved[p] = w;
                        if (p == 2)
                            close_twelve(3, len32);
                    end
                end
                else
                    mix_tail(p, l, w);
            end

            if (!last)
            begin
                if (p < POS_LIMIT)
                    pos = p + 1;
                return;
            end

            pos = 0;
            if (l == 0)
            begin
                res.hash  = '0;
                res.index = '0;
                owed_hashes.push_back(res);
                return;
            end
            // key ended before its lane blocks or twelve bytes were complete
            if (l >= 16 && p + 1 < bw)
                acc = merge_lanes(4) + len32;
            if (l == 12 && p < 2)
                close_twelve(p + 1, len32);

            h = acc;
            h = h ^ (h >> 15);
            h = h * PRIME2;
            h = h ^ (h >> 13);
            h = h * PRIME3;
            h = h ^ (h >> 16);

            res.hash = h;
            if (tbits == 0 || tbits > 32)
                res.index = '0;
            else
            begin
                mask      = (64'd1 << tbits) - 64'd1;
                res.index = h & mask[WORD_W-1:0];
            end
            owed_hashes.push_back(res);
        endfunction

        function void flag(string what, logic [WORD_W-1:0] e, logic [WORD_W-1:0] a);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h, got %h at %0t", what, e, a, $realtime);
        endfunction

        function void check_result(logic [WORD_W-1:0] hash, logic [WORD_W-1:0] index);
            hash_result_t exp_res;
            if (owed_hashes.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: hash %h index %h at %0t", hash, index,
                             $realtime);
                return;
            end
            exp_res = owed_hashes.pop_front();
            if (hash !== exp_res.hash)
                flag("hash_value", exp_res.hash, hash);
            if (index !== exp_res.index)
                flag("table_index", exp_res.index, index);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;   // key_word[31:0], key_length[47:32]
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [63:0]         m_tdata;   // hash_value[31:0], table_index[63:32]
    logic                cfg_we;
    logic                cfg_index;
    logic [WORD_W-1:0]   cfg_data;

    key_hash_tracker tracker;
    bit quiet;
    bit hold_req;
    int words_sent;

    xxhash_style_byte_key_hash_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result ready with random stalls and one long hold-off
    initial
    begin : ready_drive
        int stall_left;
        bit rdy;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_LONG;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            m_tready <= rdy;
        end
    end

    // result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.check_result(m_tdata[31:0], m_tdata[63:32]);
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    // offer one key word, with an occasional gap before it
    task automatic send_word(logic [WORD_W-1:0] w, logic [LEN_W-1:0] len, bit last);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {len, w};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        tracker.note_word(w, len, last);
        words_sent++;
    endtask

    task automatic send_key(int len, int n);
        for (int i = 0; i < n; i++)
            send_word(pick_word(), len[LEN_W-1:0], i == n - 1);
    endtask

    task automatic write_reg(logic idx, logic [WORD_W-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.set_reg(idx, d);
    endtask

    // let every owed hash come out, then give the sequencer time to go idle
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // mostly well-formed keys, some broken or odd ones
    task automatic send_random_key();
        int r;
        int len;
        int n;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_key(0, $urandom_range(1, 3));
        else if (r < 18)
            send_key(12, $urandom_range(1, 4));
        else if (r < 60)
        begin
            len = $urandom_range(1, 40);
            send_key(len, (len + 3) / 4);
        end
        else if (r < 75)
        begin
            len = $urandom_range(41, 160);
            send_key(len, (len + 3) / 4);
        end
        else if (r < 85)
        begin
            // extra words past the length
            len = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 64);
            send_key(len, (len + 3) / 4 + $urandom_range(1, 2));
        end
        else if (r < 93)
            // any length, cut short by an early last word
            send_key($urandom_range(1, 65535), $urandom_range(1, 6));
        else
        begin
            // length changes from word to word
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    0: len = 12;
                    1: len = 16;
                    default: len = $urandom_range(0, 80);
                endcase
                send_word(pick_word(), len[LEN_W-1:0], i == n - 1);
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [WORD_W-1:0] seeds [6];
        logic [WORD_W-1:0] widths [6];
        int base;
        int keys;

        tracker    = new();
        quiet      = 1'b0;
        hold_req   = 1'b0;
        words_sent = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_HASH_SEED;
        cfg_data   = '0;

        seeds[0]  = '0;           widths[0] = 32'd1;
        seeds[1]  = '1;           widths[1] = 32'd0;
        seeds[2]  = $urandom();   widths[2] = 32'd63;
        seeds[3]  = $urandom();   widths[3] = 32'd33;
        seeds[4]  = $urandom();   widths[4] = $urandom_range(2, 31);
        seeds[5]  = $urandom();   widths[5] = 32'd32;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed keys under the reset configuration
        send_word(32'h0000_0000, 16'd0, 1'b1);          // zero length
        send_word(32'hffff_ffff, 16'd0, 1'b0);
        send_word(32'h1234_5678, 16'd0, 1'b1);
        send_word(32'hffff_ffff, 16'd1, 1'b1);          // bytes past the length
        send_word(32'h00a5_a5a5, 16'd3, 1'b1);
        send_word(32'hdead_beef, 16'd4, 1'b1);
        send_word(32'h0000_0000, 16'd12, 1'b0);         // twelve bytes
        send_word(32'hffff_ffff, 16'd12, 1'b0);
        send_word(32'h8000_0001, 16'd12, 1'b1);
        send_word(32'h5555_aaaa, 16'd12, 1'b1);         // twelve, early last
        send_word(32'h0000_0000, 16'd16, 1'b0);         // one lane block
        send_word(32'hffff_ffff, 16'd16, 1'b0);
        send_word(32'h0f0f_0f0f, 16'd16, 1'b0);
        send_word(32'hf0f0_f0f0, 16'd16, 1'b1);
        send_word(32'h1111_2222, 16'd17, 1'b0);         // lane key, early last
        send_word(32'h3333_4444, 16'd17, 1'b1);
        send_word(32'h0102_0304, 16'd5, 1'b0);          // word past the length
        send_word(32'h0506_0708, 16'd5, 1'b0);
        send_word(32'hffff_ffff, 16'd5, 1'b1);
        send_word(32'hcafe_f00d, 16'd8, 1'b0);          // changing length
        send_word(32'hbead_feed, 16'd20, 1'b1);

        // longest length, cut short by an early last word
        send_key(65535, 24);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            write_reg(REG_HASH_SEED, seeds[ph]);
            write_reg(REG_TABLE_BITS, widths[ph]);
            base = words_sent;
            keys = 0;
            while (words_sent - base < PHASE_WORDS)
            begin
                if (ph == 1 && keys == 8)
                    hold_req = 1'b1;
                if (ph == 5 && words_sent - base >= 70)
                    quiet = 1'b1;
                send_random_key();
                keys++;
            end
        end

        settle();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
